### hdl/scc_pkg.sv
// Package for the sensor frame CRC check and conversion core.
// Holds the CRC-8 constants and function, the scaling constants and the shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion: temp = floor(17500 * raw / 65535) - 4500, hum = floor(10000 * raw / 65535).
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

  // Position of the next byte inside the six-byte frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // One received byte as held in the input register.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  // One completed frame, passed from the frame tracker to the converter.
  typedef struct packed {
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        temperature_crc_error;
    logic        humidity_crc_error;
  } frame_rec_t;

  // Feeds one byte into the CRC, one shift per bit.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/scc_in_if.sv
// Byte input channel of the sensor frame core: valid/ready handshake plus payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface scc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

### hdl/scc_out_if.sv
// Result channel of the sensor frame core: valid/ready handshake plus converted values.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface scc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic        [15:0] temperature_raw;
  logic        [15:0] humidity_raw;
  logic               temperature_crc_error;
  logic               humidity_crc_error;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output temperature_raw, output humidity_raw,
                  output temperature_crc_error, output humidity_crc_error, input ready);
  modport sink (input valid, input temperature_centi, input humidity_crc_error,
                input humidity_centi, input temperature_raw, input humidity_raw,
                input temperature_crc_error, output ready);
endinterface

`default_nettype wire

### hdl/scc_frame.sv
// Frame tracker: byte position, running CRC and held words; emits one record per frame.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_frame (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire scc_pkg::in_item_t   item,
  output logic                     item_ready,
  output logic                     rec_valid,
  output scc_pkg::frame_rec_t      rec,
  input  wire logic                rec_ready
);
  import scc_pkg::*;

  pos_t        pos_r, pos_nxt, pos_cur;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] t_word_r, t_word_nxt;
  logic [15:0] h_word_r, h_word_nxt;
  logic        t_bad_r, t_bad_nxt;
  logic        rec_v_r, rec_v_nxt;
  frame_rec_t  rec_r, rec_nxt;
  logic        fire;

  assign item_ready = !rec_v_r || rec_ready;
  assign fire       = item_valid && item_ready;
  assign rec_valid  = rec_v_r;
  assign rec        = rec_r;

  assign pos_cur = item.frame_start ? POS_T_HI : pos_r;

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    hi_nxt     = hi_r;
    t_word_nxt = t_word_r;
    h_word_nxt = h_word_r;
    t_bad_nxt  = t_bad_r;
    rec_nxt    = rec_r;
    rec_v_nxt  = rec_v_r && !rec_ready;
    if (fire) begin
      rec_v_nxt = 1'b0;
      unique case (pos_cur)
        POS_T_LO: begin
          crc_nxt    = crc8_feed(crc_r, item.rx_byte);
          t_word_nxt = {hi_r, item.rx_byte};
          pos_nxt    = POS_T_CRC;
        end
        POS_T_CRC: begin
          t_bad_nxt = (item.rx_byte != crc_r);
          crc_nxt   = CRC_INIT;
          pos_nxt   = POS_H_HI;
        end
        POS_H_HI: begin
          crc_nxt = crc8_feed(CRC_INIT, item.rx_byte);
          hi_nxt  = item.rx_byte;
          pos_nxt = POS_H_LO;
        end
        POS_H_LO: begin
          crc_nxt    = crc8_feed(crc_r, item.rx_byte);
          h_word_nxt = {hi_r, item.rx_byte};
          pos_nxt    = POS_H_CRC;
        end
        POS_H_CRC: begin
          rec_nxt.temperature_raw       = t_word_r;
          rec_nxt.humidity_raw          = h_word_r;
          rec_nxt.temperature_crc_error = t_bad_r;
          rec_nxt.humidity_crc_error    = (item.rx_byte != crc_r);
          rec_v_nxt = 1'b1;
          crc_nxt   = CRC_INIT;
          pos_nxt   = POS_T_HI;
        end
        default: begin
          // First byte of a frame; unused position codes land here as well.
          crc_nxt = crc8_feed(CRC_INIT, item.rx_byte);
          hi_nxt  = item.rx_byte;
          pos_nxt = POS_T_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_T_HI;
      crc_r    <= CRC_INIT;
      hi_r     <= '0;
      t_word_r <= '0;
      h_word_r <= '0;
      t_bad_r  <= 1'b0;
      rec_v_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hi_r     <= hi_nxt;
      t_word_r <= t_word_nxt;
      h_word_r <= h_word_nxt;
      t_bad_r  <= t_bad_nxt;
      rec_v_r  <= rec_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

`default_nettype wire

### hdl/scc_conv.sv
// Converter: scales the raw words (product stage) and divides by 65535 (result stage).
// Depends on scc_pkg and scc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module scc_conv (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rec_valid,
  input  wire scc_pkg::frame_rec_t rec,
  output logic                     rec_ready,
  scc_out_if.source                out_ch
);
  import scc_pkg::*;

  // floor(x / 65535) for x below 2^31: x>>16 is low by at most one, and the
  // remainder against that estimate stays below twice the divisor.
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] rem;
    q0  = x[30:16];
    rem = {1'b0, x[15:0]} + {2'b00, q0};
    return (rem >= {1'b0, FULL_SCALE}) ? q0 + 15'd1 : q0;
  endfunction

  // Product stage.
  logic        p_v_r, p_v_nxt;
  logic [30:0] t_prod_r, t_prod_nxt;
  logic [29:0] h_prod_r, h_prod_nxt;
  frame_rec_t  p_rec_r, p_rec_nxt;
  logic        p_ready;

  // Result stage.
  logic               o_v_r, o_v_nxt;
  logic signed [14:0] o_temp_r, o_temp_nxt;
  logic        [13:0] o_hum_r, o_hum_nxt;
  frame_rec_t         o_rec_r, o_rec_nxt;
  logic               o_ready;
  logic        [14:0] t_quot, h_quot;

  assign o_ready   = !o_v_r || out_ch.ready;
  assign p_ready   = !p_v_r || o_ready;
  assign rec_ready = p_ready;

  assign t_quot = div_full_scale(t_prod_r);
  assign h_quot = div_full_scale({1'b0, h_prod_r});

  always_comb begin
    p_v_nxt    = p_ready ? rec_valid : p_v_r;
    t_prod_nxt = t_prod_r;
    h_prod_nxt = h_prod_r;
    p_rec_nxt  = p_rec_r;
    if (rec_valid && p_ready) begin
      t_prod_nxt = 31'(rec.temperature_raw) * 31'(TEMP_SCALE);
      h_prod_nxt = 30'(rec.humidity_raw) * 30'(HUM_SCALE);
      p_rec_nxt  = rec;
    end

    o_v_nxt    = o_ready ? p_v_r : o_v_r;
    o_temp_nxt = o_temp_r;
    o_hum_nxt  = o_hum_r;
    o_rec_nxt  = o_rec_r;
    if (p_v_r && o_ready) begin
      o_temp_nxt = signed'(t_quot - TEMP_OFFSET);
      o_hum_nxt  = h_quot[13:0];
      o_rec_nxt  = p_rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      p_v_r <= p_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_prod_r <= t_prod_nxt;
    h_prod_r <= h_prod_nxt;
    p_rec_r  <= p_rec_nxt;
    o_temp_r <= o_temp_nxt;
    o_hum_r  <= o_hum_nxt;
    o_rec_r  <= o_rec_nxt;
  end

  assign out_ch.valid                 = o_v_r;
  assign out_ch.temperature_centi     = o_temp_r;
  assign out_ch.humidity_centi        = o_hum_r;
  assign out_ch.temperature_raw       = o_rec_r.temperature_raw;
  assign out_ch.humidity_raw          = o_rec_r.humidity_raw;
  assign out_ch.temperature_crc_error = o_rec_r.temperature_crc_error;
  assign out_ch.humidity_crc_error    = o_rec_r.humidity_crc_error;

endmodule

`default_nettype wire

### hdl/sensor_frame_crc_convert_core.sv
// Top level of the sensor frame core; uses scc_pkg, both channel interfaces and the stages.
// Path: a frame's sixth byte goes through the input register, the frame record register and
// the product and result stages. Throughput: one byte transaction per cycle, one result per
// six bytes; the input stalls only once the input register holds a byte, the record, product
// and result stages all hold a frame and the output is not ready.
// Reset: synchronous, active-low rst_n clears all valid bits, the byte position,
// the running CRC (to 0xFF) and the held words and flag.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_crc_convert_core (
  input  wire logic clk,
  input  wire logic rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch
);
  import scc_pkg::*;

  // The input register holds one accepted byte transaction. It frees up
  // whenever the frame tracker takes its content, so back-to-back bytes pass.
  logic     in_v_r, in_v_nxt;
  in_item_t in_item_r, in_item_nxt;
  logic     frm_item_ready;
  logic     in_fire;

  // Completed frame record between the tracker and the converter.
  logic       rec_valid;
  logic       rec_ready;
  frame_rec_t rec;

  assign in_ch.ready = !in_v_r || frm_item_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt    = in_ch.ready ? in_ch.valid : in_v_r;
    in_item_nxt = in_item_r;
    if (in_fire) begin
      in_item_nxt.rx_byte     = in_ch.rx_byte;
      in_item_nxt.frame_start = in_ch.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
  end

  // Tracks the position in the frame and checks each word's CRC. Only the
  // sixth byte produces a record; the other bytes just update state.
  scc_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_v_r),
    .item       (in_item_r),
    .item_ready (frm_item_ready),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .rec_ready  (rec_ready)
  );

  // Scales both words with a constant multiply, then divides by 65535 with a
  // shift and one correction step, and applies the temperature offset.
  scc_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready),
    .out_ch    (out_ch)
  );

  // A held input byte that is not taken by the tracker stays in place.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !frm_item_ready |=> in_v_r && $stable(in_item_r))
    else $error("input register lost a byte while the frame tracker stalled");

  // Humidity never exceeds 100.00 percent.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.humidity_centi <= 14'd10000)
    else $error("humidity result out of range");

  // Temperature stays within -45.00 .. 130.00 degrees.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.temperature_centi >= -15'sd4500
                  && out_ch.temperature_centi <= 15'sd13000)
    else $error("temperature result out of range");

  // Full scale maps to the top of the range and nothing else does.
  a_temp_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.temperature_raw == 16'hFFFF)
                   == (out_ch.temperature_centi == 15'sd13000)))
    else $error("temperature division correction mismatch at full scale");

endmodule

`default_nettype wire
